/* src/rsh_pkg.sv */
// Package for the ray-sphere hit test unit.
// Holds the multiplier limb width, a width helper and the late flag bundle.
// No dependencies.
`timescale 1ns / 1ps

package rsh_pkg;

	// Width of one operand slice in the multiplier pipelines.
	localparam int MUL_LIMB = 33;

	// Number of axes in a vector.
	localparam int NUM_AXES = 3;

	function automatic int imax(input int x, input int y);
		return (x > y) ? x : y;
	endfunction

	// Decisions taken before f(T) is known, carried to the final stage.
	typedef struct packed {
		logic dir_zero;
		logic disc_ok;
		logic b_nonpos;
		logic h_nonneg;
	} rsh_flags_t;

endpackage

/* src/rsh_mul.sv */
// Three-stage unsigned multiplier built from MUL_LIMB-wide partial products.
// Depends on rsh_pkg. Operand a must span at most two limbs.
`timescale 1ns / 1ps

module rsh_mul
	import rsh_pkg::*;
#(
	parameter int A_BITS = 33,
	parameter int B_BITS = 33
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [A_BITS-1:0]        a,
	input  logic [B_BITS-1:0]        b,
	output logic [A_BITS+B_BITS-1:0] p
);

	localparam int NA  = (A_BITS + MUL_LIMB - 1) / MUL_LIMB;
	localparam int NB  = (B_BITS + MUL_LIMB - 1) / MUL_LIMB;
	localparam int PW  = A_BITS + B_BITS;
	localparam int PPW = 2 * MUL_LIMB;
	localparam int RW  = (NB + 1) * MUL_LIMB;

	logic [NA*MUL_LIMB-1:0] a_ext;
	logic [NB*MUL_LIMB-1:0] b_ext;
	logic [PPW-1:0]         pp_s1 [NA][NB];
	logic [RW-1:0]          row_even [NA];
	logic [RW-1:0]          row_odd [NA];
	logic [RW-1:0]          row_s2 [NA];
	logic [PW-1:0]          sum_d;
	logic [PW-1:0]          p_s3;

	assign a_ext = (NA*MUL_LIMB)'(a);
	assign b_ext = (NB*MUL_LIMB)'(b);

	// Partial products, one per limb pair.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s1[i][j] <= PPW'(a_ext[i*MUL_LIMB +: MUL_LIMB])
						* PPW'(b_ext[j*MUL_LIMB +: MUL_LIMB]);
				end
			end
		end
	end

	// Even and odd partials of a row do not overlap: pack them, then one add.
	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_even[i] = '0;
			row_odd[i]  = '0;
			for (int j = 0; j < NB; j++) begin
				if ((j & 1) == 0) begin
					row_even[i][j*MUL_LIMB +: PPW] = pp_s1[i][j];
				end else begin
					row_odd[i][j*MUL_LIMB +: PPW] = pp_s1[i][j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				row_s2[i] <= row_even[i] + row_odd[i];
			end
		end
	end

	// Fold the rows; the true product fits PW bits, so wrap-around is harmless.
	always_comb begin
		sum_d = '0;
		for (int i = 0; i < NA; i++) begin
			sum_d = sum_d + (PW'(row_s2[i]) << (i * MUL_LIMB));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s3 <= sum_d;
		end
	end

	assign p = p_s3;

endmodule

/* src/ray_sphere_hit_test_unit.sv */
// Ray-sphere hit test: fully pipelined, one query per clock while in_ready is high, exact integer arithmetic.
// Accepts a query every cycle while the skid stage is empty and returns hit through the output
// register; results leave in order, one per query. The pipeline is built around
// three multiplier passes in series (coefficients, discriminant and f(T) terms, and
// the final scaling by max_distance), each a three-deep pipeline of 33-bit partial
// products, plus the add and sign stages between them. With m = origin - center,
// a = d.d, B = m.d, C = m.m - r^2 and M = max_distance, the unit tests the signs of
// C, of M*(a*M + 2^(F+1)*B) + 2^(2F)*C and of B^2 - a*C, and whether the vertex -B/a
// lies in [0, M/2^F]; both ends of the range count as hits, a tangent ray counts as a
// hit and a zero direction is a miss. An output register plus a one-entry skid stage
// part the two sides, so a new query is taken while a finished result waits; ready
// drops only once the skid stage is full. Depends on rsh_pkg and rsh_mul.
`timescale 1ns / 1ps

module ray_sphere_hit_test_unit
	import rsh_pkg::*;
#(
	parameter int COORD_BITS = 24,
	parameter int FRAC_BITS  = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] center_x,
	input  logic signed [COORD_BITS-1:0] center_y,
	input  logic signed [COORD_BITS-1:0] center_z,
	input  logic        [COORD_BITS-2:0] sphere_radius,
	input  logic signed [COORD_BITS-1:0] origin_x,
	input  logic signed [COORD_BITS-1:0] origin_y,
	input  logic signed [COORD_BITS-1:0] origin_z,
	input  logic signed [COORD_BITS-1:0] dir_x,
	input  logic signed [COORD_BITS-1:0] dir_y,
	input  logic signed [COORD_BITS-1:0] dir_z,
	input  logic        [COORD_BITS-2:0] max_distance,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         hit
);

	// Widths of the exact intermediate values.
	localparam int CB   = COORD_BITS;
	localparam int MW   = CB + 1;                               // m = o - c, and |m|
	localparam int DW   = CB;                                   // |d|
	localparam int RDW  = CB - 1;                               // radius, max distance
	localparam int AW   = 2 * CB;                               // a = d.d
	localparam int BW   = 2 * CB + 2;                           // B, signed
	localparam int BAW  = 2 * CB + 1;                           // |B|
	localparam int CW   = 2 * CB + 3;                           // C, signed
	localparam int CAW  = 2 * CB + 2;                           // |C|
	localparam int AMW  = AW + RDW;                             // a*M
	localparam int GW   = imax(AMW + 1, BW + FRAC_BITS + 1) + 1;  // g and h, signed
	localparam int GAW  = GW - 1;                               // |g|
	localparam int GMW  = RDW + GAW;                            // M*|g|
	localparam int FW   = imax(GMW + 1, CW + 2 * FRAC_BITS) + 1;  // 2^(2F) f(T), signed
	localparam int NSTG = 17;

	// Pipeline control
	logic            en;
	logic            push;
	logic [NSTG:1]   stage_vld_q;
	logic            out_valid_q;
	logic            skid_valid_q;
	logic            hit_q;
	logic            skid_hit_q;
	logic            hit_d;

	// Stage 1 and 2: offsets and magnitudes
	logic signed [CB-1:0]  c_in [NUM_AXES];
	logic signed [CB-1:0]  o_in [NUM_AXES];
	logic signed [CB-1:0]  d_in [NUM_AXES];
	logic signed [MW-1:0]  m_s1 [NUM_AXES];
	logic signed [DW-1:0]  d_s1 [NUM_AXES];
	logic [RDW-1:0]        r_s1;
	logic [MW-1:0]         mabs_s2 [NUM_AXES];
	logic [DW-1:0]         dabs_s2 [NUM_AXES];
	logic [NUM_AXES-1:0]   mdneg_s2, mdneg_s3, mdneg_s4, mdneg_s5;
	logic [RDW-1:0]        r_s2;

	// Max distance travels to the two multiplier passes that need it
	logic [RDW-1:0] mx_s1, mx_s2, mx_s3, mx_s4, mx_s5, mx_s6, mx_s7, mx_s8;
	logic [RDW-1:0] mx_s9, mx_s10, mx_s11, mx_s12, mx_s13;

	// Stage 5 products, stage 6 to 8 coefficients
	logic [AW-1:0]         dd_s5 [NUM_AXES];
	logic [BAW-1:0]        md_s5 [NUM_AXES];
	logic [2*MW-1:0]       mm_s5 [NUM_AXES];
	logic [2*RDW-1:0]      rr_s5;
	logic signed [BW-1:0]  md_sgn [NUM_AXES];
	logic signed [BW-1:0]  b_sum;
	logic [AW-1:0]         a_s6, a_s7, a_s8;
	logic signed [BW-1:0]  b_s6, b_s7, b_s8, b_s9, b_s10, b_s11;
	logic signed [CW-1:0]  cp_s6, cq_s6;
	logic signed [CW-1:0]  c_s7, c_s8, c_s9, c_s10, c_s11, c_s12, c_s13;
	logic signed [CW-1:0]  c_s14, c_s15, c_s16;
	logic [BAW-1:0]        babs_s7, babs_s8;
	logic [CAW-1:0]        cabs_s8;
	logic                  azero_s8, azero_s9, azero_s10, azero_s11;

	// Stage 11 to 17: discriminant, f(T) and vertex
	logic [AMW-1:0]        am_s11;
	logic [2*BAW-1:0]      bb_s11;
	logic [2*BAW-1:0]      ac_s11;
	logic signed [GW-1:0]  g_d;
	logic signed [GW-1:0]  h_d;
	logic signed [GW-1:0]  g_s12;
	logic [GAW-1:0]        gabs_s13;
	logic                  gneg_s13, gneg_s14, gneg_s15, gneg_s16;
	rsh_flags_t            flags_s12, flags_s13, flags_s14, flags_s15, flags_s16, flags_s17;
	logic [GMW-1:0]        gm_s16;
	logic signed [FW-1:0]  cs_d;
	logic signed [FW-1:0]  gmx_d;
	logic signed [FW-1:0]  ft_s17;
	logic                  czero_s17, cneg_s17;
	logic                  ftzero, ftneg;

	// ---------------------------------------------------------------------------------
	// Flow control: the whole pipe advances unless the skid stage holds a result.
	// ---------------------------------------------------------------------------------
	assign en       = !skid_valid_q;
	assign in_ready = en;
	assign push     = en && stage_vld_q[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else if (en) begin
			stage_vld_q <= {stage_vld_q[NSTG-1:1], in_valid};
		end
	end

	// ---------------------------------------------------------------------------------
	// Stage 1: form m = o - c per axis, register direction, radius and distance.
	// ---------------------------------------------------------------------------------
	assign c_in[0] = center_x;
	assign c_in[1] = center_y;
	assign c_in[2] = center_z;
	assign o_in[0] = origin_x;
	assign o_in[1] = origin_y;
	assign o_in[2] = origin_z;
	assign d_in[0] = dir_x;
	assign d_in[1] = dir_y;
	assign d_in[2] = dir_z;

	// The signed sum of m.d terms for stage 6.
	always_comb begin
		for (int k = 0; k < NUM_AXES; k++) begin
			md_sgn[k] = mdneg_s5[k] ? -$signed(BW'(md_s5[k])) : $signed(BW'(md_s5[k]));
		end
		b_sum = md_sgn[0] + md_sgn[1] + md_sgn[2];
	end

	// g = a*M + 2^(F+1)*B feeds f(T); h = a*M + 2^F*B decides the vertex position.
	assign g_d = $signed(GW'(am_s11)) + ($signed(GW'(b_s11)) <<< (FRAC_BITS + 1));
	assign h_d = $signed(GW'(am_s11)) + ($signed(GW'(b_s11)) <<< FRAC_BITS);

	// 2^(2F) f(T) = +-M*|g| + 2^(2F)*C
	assign cs_d  = $signed(FW'(c_s16)) <<< (2 * FRAC_BITS);
	assign gmx_d = $signed(FW'(gm_s16));

	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 1
			for (int k = 0; k < NUM_AXES; k++) begin
				m_s1[k] <= {o_in[k][CB-1], o_in[k]} - {c_in[k][CB-1], c_in[k]};
				d_s1[k] <= d_in[k];
			end
			r_s1  <= sphere_radius;
			mx_s1 <= max_distance;

			// Stage 2: magnitudes for the unsigned multipliers, product signs aside
			for (int k = 0; k < NUM_AXES; k++) begin
				mabs_s2[k]  <= m_s1[k][MW-1] ? MW'(-m_s1[k]) : MW'(m_s1[k]);
				dabs_s2[k]  <= d_s1[k][DW-1] ? DW'(-d_s1[k]) : DW'(d_s1[k]);
				mdneg_s2[k] <= m_s1[k][MW-1] ^ d_s1[k][DW-1];
			end
			r_s2  <= r_s1;
			mx_s2 <= mx_s1;

			// Stages 3 to 5: hold alongside the first multiplier pass
			mdneg_s3 <= mdneg_s2;
			mdneg_s4 <= mdneg_s3;
			mdneg_s5 <= mdneg_s4;
			mx_s3    <= mx_s2;
			mx_s4    <= mx_s3;
			mx_s5    <= mx_s4;

			// Stage 6: a and B in full, C in two halves
			a_s6  <= dd_s5[0] + dd_s5[1] + dd_s5[2];
			b_s6  <= b_sum;
			cp_s6 <= $signed(CW'(mm_s5[0])) + $signed(CW'(mm_s5[1]));
			cq_s6 <= $signed(CW'(mm_s5[2])) - $signed(CW'(rr_s5));
			mx_s6 <= mx_s5;

			// Stage 7: finish C, take |B|
			a_s7    <= a_s6;
			b_s7    <= b_s6;
			babs_s7 <= b_s6[BW-1] ? BAW'(-b_s6) : BAW'(b_s6);
			c_s7    <= cp_s6 + cq_s6;
			mx_s7   <= mx_s6;

			// Stage 8: take |C|, note a zero direction
			a_s8     <= a_s7;
			b_s8     <= b_s7;
			babs_s8  <= babs_s7;
			c_s8     <= c_s7;
			cabs_s8  <= c_s7[CW-1] ? CAW'(-c_s7) : CAW'(c_s7);
			azero_s8 <= (a_s7 == '0);
			mx_s8    <= mx_s7;

			// Stages 9 to 11: hold alongside the second multiplier pass
			b_s9      <= b_s8;
			b_s10     <= b_s9;
			b_s11     <= b_s10;
			c_s9      <= c_s8;
			c_s10     <= c_s9;
			c_s11     <= c_s10;
			azero_s9  <= azero_s8;
			azero_s10 <= azero_s9;
			azero_s11 <= azero_s10;
			mx_s9     <= mx_s8;
			mx_s10    <= mx_s9;
			mx_s11    <= mx_s10;

			// Stage 12: discriminant sign, vertex test, g
			g_s12              <= g_d;
			flags_s12.dir_zero <= azero_s11;
			flags_s12.disc_ok  <= c_s11[CW-1] || (bb_s11 >= ac_s11);
			flags_s12.b_nonpos <= b_s11[BW-1] || (b_s11 == '0);
			flags_s12.h_nonneg <= !h_d[GW-1];
			c_s12              <= c_s11;
			mx_s12             <= mx_s11;

			// Stage 13: |g| for the last multiplier pass
			gabs_s13  <= g_s12[GW-1] ? GAW'(-g_s12) : GAW'(g_s12);
			gneg_s13  <= g_s12[GW-1];
			flags_s13 <= flags_s12;
			c_s13     <= c_s12;
			mx_s13    <= mx_s12;

			// Stages 14 to 16: hold alongside the last multiplier pass
			gneg_s14  <= gneg_s13;
			gneg_s15  <= gneg_s14;
			gneg_s16  <= gneg_s15;
			flags_s14 <= flags_s13;
			flags_s15 <= flags_s14;
			flags_s16 <= flags_s15;
			c_s14     <= c_s13;
			c_s15     <= c_s14;
			c_s16     <= c_s15;

			// Stage 17: scaled f(T)
			ft_s17    <= gneg_s16 ? (cs_d - gmx_d) : (cs_d + gmx_d);
			czero_s17 <= (c_s16 == '0);
			cneg_s17  <= c_s16[CW-1];
			flags_s17 <= flags_s16;
		end
	end

	// ---------------------------------------------------------------------------------
	// Multiplier passes. First: squares and cross terms per axis, and r^2.
	// ---------------------------------------------------------------------------------
	for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
		rsh_mul #(.A_BITS(DW), .B_BITS(DW)) u_dd (
			.clk (clk),
			.en  (en),
			.a   (dabs_s2[k]),
			.b   (dabs_s2[k]),
			.p   (dd_s5[k])
		);

		rsh_mul #(.A_BITS(DW), .B_BITS(MW)) u_md (
			.clk (clk),
			.en  (en),
			.a   (dabs_s2[k]),
			.b   (mabs_s2[k]),
			.p   (md_s5[k])
		);

		rsh_mul #(.A_BITS(MW), .B_BITS(MW)) u_mm (
			.clk (clk),
			.en  (en),
			.a   (mabs_s2[k]),
			.b   (mabs_s2[k]),
			.p   (mm_s5[k])
		);
	end

	rsh_mul #(.A_BITS(RDW), .B_BITS(RDW)) u_rr (
		.clk (clk),
		.en  (en),
		.a   (r_s2),
		.b   (r_s2),
		.p   (rr_s5)
	);

	// Second: a*M, B^2 and a*|C|.
	rsh_mul #(.A_BITS(RDW), .B_BITS(AW)) u_am (
		.clk (clk),
		.en  (en),
		.a   (mx_s8),
		.b   (a_s8),
		.p   (am_s11)
	);

	rsh_mul #(.A_BITS(BAW), .B_BITS(BAW)) u_bb (
		.clk (clk),
		.en  (en),
		.a   (babs_s8),
		.b   (babs_s8),
		.p   (bb_s11)
	);

	rsh_mul #(.A_BITS(AW), .B_BITS(CAW)) u_ac (
		.clk (clk),
		.en  (en),
		.a   (a_s8),
		.b   (cabs_s8),
		.p   (ac_s11)
	);

	// Third: M*|g|.
	rsh_mul #(.A_BITS(RDW), .B_BITS(GAW)) u_gm (
		.clk (clk),
		.en  (en),
		.a   (mx_s13),
		.b   (gabs_s13),
		.p   (gm_s16)
	);

	// ---------------------------------------------------------------------------------
	// Decision. A root at either end, or a sign change across [0, T], is a hit.
	// With both ends outside the sphere, the vertex must lie in range instead.
	// ---------------------------------------------------------------------------------
	assign ftzero = (ft_s17 == '0);
	assign ftneg  = ft_s17[FW-1];
	assign hit_d  = !flags_s17.dir_zero && flags_s17.disc_ok
		&& (czero_s17 || ftzero || (cneg_s17 != ftneg)
		|| (!cneg_s17 && flags_s17.b_nonpos && flags_s17.h_nonneg));

	// ---------------------------------------------------------------------------------
	// Output register and skid stage. Park a new result in the skid stage when the
	// output is stalled; refill the output from the skid stage once it is taken.
	// ---------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && !out_ready) begin
			if (push) begin
				skid_valid_q <= 1'b1;
			end
		end else if (skid_valid_q) begin
			out_valid_q  <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && !out_ready) begin
			if (push) begin
				skid_hit_q <= hit_d;
			end
		end else if (skid_valid_q) begin
			hit_q <= skid_hit_q;
		end else if (push) begin
			hit_q <= hit_d;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;

	// ---------------------------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------------------------
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage holds a result while the output is empty");

	a_stalled_push_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready && push) |=> skid_valid_q)
		else $error("result arriving at a stalled output was dropped");

	a_freeze_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(stage_vld_q))
		else $error("pipeline moved while frozen");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ready && skid_valid_q) |=> (out_valid_q && !skid_valid_q))
		else $error("skid result lost after an output transfer");

endmodule

/* verif/tb_ray_sphere_hit_test_unit.sv */
// Testbench for ray_sphere_hit_test_unit: directed and random ray queries, exact hit prediction.
// Depends on ray_sphere_hit_test_unit (and through it rsh_pkg); drives both valid/ready channels.
`timescale 1ns / 1ps

module tb_ray_sphere_hit_test_unit;

	localparam int COORD_BITS = 24;
	localparam int FRAC_BITS  = 8;
	localparam int ONE        = 1 << FRAC_BITS;    // 1.0 in fixed point
	localparam int CMAX       = (1 << (COORD_BITS - 1)) - 1;
	localparam int CMIN       = -(1 << (COORD_BITS - 1));
	localparam int UMAX       = (1 << (COORD_BITS - 1)) - 1;
	localparam int N_RANDOM   = 400;
	localparam int QUIET_LIMIT = 2000;             // cycles without any transfer
	localparam int DRAIN_CYCLES = 40;

	// Wide enough that no product of the hit test can overflow.
	typedef logic signed [255:0] exact_t;

	typedef struct {
		logic signed [COORD_BITS-1:0] cx, cy, cz;
		logic        [COORD_BITS-2:0] radius;
		logic signed [COORD_BITS-1:0] ox, oy, oz;
		logic signed [COORD_BITS-1:0] dx, dy, dz;
		logic        [COORD_BITS-2:0] max_dist;
	} ray_query_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                         in_valid      = 1'b0;
	logic                         in_ready;
	logic signed [COORD_BITS-1:0] center_x      = '0;
	logic signed [COORD_BITS-1:0] center_y      = '0;
	logic signed [COORD_BITS-1:0] center_z      = '0;
	logic        [COORD_BITS-2:0] sphere_radius = '0;
	logic signed [COORD_BITS-1:0] origin_x      = '0;
	logic signed [COORD_BITS-1:0] origin_y      = '0;
	logic signed [COORD_BITS-1:0] origin_z      = '0;
	logic signed [COORD_BITS-1:0] dir_x         = '0;
	logic signed [COORD_BITS-1:0] dir_y         = '0;
	logic signed [COORD_BITS-1:0] dir_z         = '0;
	logic        [COORD_BITS-2:0] max_distance  = '0;
	logic                         out_valid;
	logic                         out_ready     = 1'b0;
	logic                         hit;

	ray_query_t query_q [$];       // queries still to be offered
	bit         expected_hits [$]; // predicted hit flags, oldest first
	ray_query_t cur_query;
	int         sent_cnt  = 0;
	int         rcvd_cnt  = 0;
	int         err_cnt   = 0;
	int         quiet_cnt = 0;

	ray_sphere_hit_test_unit #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.center_x     (center_x),
		.center_y     (center_y),
		.center_z     (center_z),
		.sphere_radius(sphere_radius),
		.origin_x     (origin_x),
		.origin_y     (origin_y),
		.origin_z     (origin_z),
		.dir_x        (dir_x),
		.dir_y        (dir_y),
		.dir_z        (dir_z),
		.max_distance (max_distance),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Exact hit decision. With m = o - c, a = d.d, B = m.d, C = m.m - r^2 and
	// f(T) scaled by 2^(2F): a*M^2 + 2*B*M*2^F + C*2^(2F). Only signs are used.
	function automatic bit ray_hits_sphere(input ray_query_t q);
		exact_t mv [3];
		exact_t dv [3];
		exact_t a, b, c, disc, f_t, mx, neg_b, vertex_gap;
		bit     hit_val;
		mv[0] = exact_t'(q.ox) - exact_t'(q.cx);
		mv[1] = exact_t'(q.oy) - exact_t'(q.cy);
		mv[2] = exact_t'(q.oz) - exact_t'(q.cz);
		dv[0] = exact_t'(q.dx);
		dv[1] = exact_t'(q.dy);
		dv[2] = exact_t'(q.dz);
		mx    = exact_t'(q.max_dist);
		a     = dv[0] * dv[0] + dv[1] * dv[1] + dv[2] * dv[2];
		b     = mv[0] * dv[0] + mv[1] * dv[1] + mv[2] * dv[2];
		c     = mv[0] * mv[0] + mv[1] * mv[1] + mv[2] * mv[2]
		      - exact_t'(q.radius) * exact_t'(q.radius);
		hit_val = 1'b0;
		// a zero direction never hits
		if (a != '0) begin
			disc = b * b - a * c;
			// a tangent ray (zero discriminant) still counts
			if (!disc[255]) begin
				f_t = a * mx * mx + ((b * mx) <<< (FRAC_BITS + 1))
				    + (c <<< (2 * FRAC_BITS));
				if (c == '0 || f_t == '0)
					hit_val = 1'b1;
				else if (c[255] != f_t[255])
					hit_val = 1'b1;
				else if (!c[255]) begin
					// both ends outside: the vertex -B/a must lie in [0, T]
					neg_b      = -b;
					vertex_gap = a * mx - (neg_b <<< FRAC_BITS);
					if (!neg_b[255] && !vertex_gap[255])
						hit_val = 1'b1;
				end
			end
		end
		return hit_val;
	endfunction

	function automatic ray_query_t make_query(input int cx, input int cy, input int cz,
			input int r, input int ox, input int oy, input int oz,
			input int dx, input int dy, input int dz, input int md);
		ray_query_t q;
		q.cx       = cx[COORD_BITS-1:0];
		q.cy       = cy[COORD_BITS-1:0];
		q.cz       = cz[COORD_BITS-1:0];
		q.radius   = r[COORD_BITS-2:0];
		q.ox       = ox[COORD_BITS-1:0];
		q.oy       = oy[COORD_BITS-1:0];
		q.oz       = oz[COORD_BITS-1:0];
		q.dx       = dx[COORD_BITS-1:0];
		q.dy       = dy[COORD_BITS-1:0];
		q.dz       = dz[COORD_BITS-1:0];
		q.max_dist = md[COORD_BITS-2:0];
		return q;
	endfunction

	// Uniform in [-2^span, 2^span - 1].
	function automatic int rand_span(input int span);
		return int'($urandom_range(0, (1 << (span + 1)) - 1)) - (1 << span);
	endfunction

	// Mostly rays aimed near the sphere at random scales, so that hits, misses,
	// tangents and inside starts all turn up; the rest is scaled and full-range noise.
	function automatic ray_query_t rand_query();
		int ctr [3];
		int org [3];
		int dir [3];
		int sel, span, dspan, shift, nspan, rad, md, i;
		bit flip, clean;
		sel = $urandom_range(0, 99);
		if (sel < 15) begin
			for (i = 0; i < 3; i++) begin
				ctr[i] = rand_span(COORD_BITS - 1);
				org[i] = rand_span(COORD_BITS - 1);
				dir[i] = rand_span(COORD_BITS - 1);
			end
			rad = $urandom_range(0, UMAX);
			md  = $urandom_range(0, UMAX);
		end else if (sel < 35) begin
			span  = $urandom_range(0, 22);
			dspan = $urandom_range(0, 22);
			for (i = 0; i < 3; i++) begin
				ctr[i] = rand_span(span);
				org[i] = rand_span(span);
				dir[i] = rand_span(dspan);
			end
			rad = $urandom_range(0, 1 << span);
			md  = $urandom_range(0, 1 << $urandom_range(0, 22));
		end else begin
			span  = $urandom_range(4, 21);
			shift = $urandom_range(0, 6);
			nspan = span - shift - 4;
			if (nspan < 0)
				nspan = 0;
			clean = ($urandom_range(0, 3) == 0);
			flip  = ($urandom_range(0, 6) == 0);
			for (i = 0; i < 3; i++) begin
				ctr[i] = rand_span(span);
				org[i] = rand_span(span);
				dir[i] = (ctr[i] - org[i]) >>> shift;
				if (!clean)
					dir[i] += rand_span(nspan);
				if (flip)
					dir[i] = -dir[i];
			end
			rad = $urandom_range(0, 1 << span);
			// the centre lies at t = 2^shift, i.e. max_distance 2^(shift+F)
			md  = $urandom_range(0, 1 << (shift + FRAC_BITS + 1));
		end
		return make_query(ctr[0], ctr[1], ctr[2], rad, org[0], org[1], org[2],
			dir[0], dir[1], dir[2], md);
	endfunction

	// Driver: offer queued queries, hold each until its transfer, then idle
	// for a drawn number of cycles (none at all in every third stretch).
	int  send_idle = 0;
	bit  load_next;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			send_idle = 0;
		end else begin
			load_next = 1'b0;
			if (in_valid && in_ready) begin
				expected_hits.push_back(ray_hits_sphere(cur_query));
				sent_cnt++;
			end
			if (!in_valid || in_ready) begin
				if (send_idle > 0)
					send_idle--;
				else if (query_q.size() > 0)
					load_next = 1'b1;
			end
			if (load_next) begin
				cur_query     = query_q.pop_front();
				center_x      <= cur_query.cx;
				center_y      <= cur_query.cy;
				center_z      <= cur_query.cz;
				sphere_radius <= cur_query.radius;
				origin_x      <= cur_query.ox;
				origin_y      <= cur_query.oy;
				origin_z      <= cur_query.oz;
				dir_x         <= cur_query.dx;
				dir_y         <= cur_query.dy;
				dir_z         <= cur_query.dz;
				max_distance  <= cur_query.max_dist;
				in_valid      <= 1'b1;
				send_idle     = ((sent_cnt % 96) < 32) ? 0 : $urandom_range(0, 4);
			end else if (in_valid && in_ready) begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: check each result transfer against the oldest prediction and
	// stall the output side for a drawn number of cycles after each one.
	int recv_stall = 0;
	bit want_hit;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			recv_stall = 0;
		end else begin
			if (out_valid && out_ready) begin
				rcvd_cnt++;
				if (expected_hits.size() == 0) begin
					$error("hit: no result expected, actual %0b", hit);
					err_cnt++;
				end else begin
					want_hit = expected_hits.pop_front();
					if (hit !== want_hit) begin
						$error("hit: expected %0b, actual %0b", want_hit, hit);
						err_cnt++;
					end
				end
				recv_stall = ((rcvd_cnt % 80) >= 56) ? 0 : $urandom_range(0, 4);
			end else if (recv_stall > 0) begin
				recv_stall--;
			end
			out_ready <= (recv_stall == 0);
		end
	end

	// Watchdog: abort when neither side has moved a transfer for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cnt = 0;
			else
				quiet_cnt++;
			if (quiet_cnt >= QUIET_LIMIT) begin
				$display("ray_sphere_hit_test_unit test failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int i;
		// Zero direction, with the origin at and then inside the sphere.
		query_q.push_back(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		query_q.push_back(make_query(0, 0, 0, 4*ONE, ONE, 0, 0, 0, 0, 0, 100*ONE));
		// Origin inside: exit root beyond T, then within T.
		query_q.push_back(make_query(0, 0, 0, 10*ONE, 0, 0, 0, ONE, 0, 0, ONE));
		query_q.push_back(make_query(0, 0, 0, 10*ONE, 0, 0, 0, ONE, 0, 0, 20*ONE));
		// Tangent ray, touching at t = 4, then with T short of it.
		query_q.push_back(make_query(0, 2*ONE, 0, 2*ONE, -4*ONE, 0, 0, ONE, 0, 0, 10*ONE));
		query_q.push_back(make_query(0, 2*ONE, 0, 2*ONE, -4*ONE, 0, 0, ONE, 0, 0, ONE));
		// Point sphere on the ray and just off it.
		query_q.push_back(make_query(ONE, 0, 0, 0, 0, 0, 0, ONE, 0, 0, 2*ONE));
		query_q.push_back(make_query(ONE, 1, 0, 0, 0, 0, 0, ONE, 0, 0, 2*ONE));
		// Root exactly at t = 0 with T = 0.
		query_q.push_back(make_query(0, 0, 0, ONE, ONE, 0, 0, ONE, 0, 0, 0));
		// Entry exactly at t = T, then one step short.
		query_q.push_back(make_query(4*ONE, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 3*ONE));
		query_q.push_back(make_query(4*ONE, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 3*ONE - 1));
		// Sphere behind the ray; outside start with T = 0.
		query_q.push_back(make_query(-4*ONE, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 100*ONE));
		query_q.push_back(make_query(4*ONE, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0));
		// Tiny diagonal direction: entry past T, entry inside T, full reach.
		query_q.push_back(make_query(3*ONE, 3*ONE, 3*ONE, ONE, 0, 0, 0, 1, 1, 1, 600*ONE));
		query_q.push_back(make_query(3*ONE, 3*ONE, 3*ONE, ONE, 0, 0, 0, 1, 1, 1, 700*ONE));
		query_q.push_back(make_query(3*ONE, 3*ONE, 3*ONE, ONE, 0, 0, 0, 1, 1, 1, 768*ONE));
		// Field extremes.
		query_q.push_back(make_query(CMAX, CMAX, CMAX, UMAX, CMAX, CMAX, CMAX,
			CMAX, CMAX, CMAX, UMAX));
		query_q.push_back(make_query(CMIN, CMIN, CMIN, 0, CMIN, CMIN, CMIN,
			CMIN, CMIN, CMIN, 0));
		query_q.push_back(make_query(CMIN, CMIN, CMIN, UMAX, CMAX, CMAX, CMAX,
			CMIN, CMIN, CMIN, UMAX));
		query_q.push_back(make_query(CMAX, CMAX, CMAX, 0, CMIN, CMIN, CMIN,
			CMAX, CMAX, CMAX, UMAX));
		query_q.push_back(make_query(CMAX, CMIN, 0, UMAX, CMIN, CMAX, 0,
			CMIN, CMAX, 1, UMAX));
		for (i = 0; i < N_RANDOM; i++)
			query_q.push_back(rand_query());

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (query_q.size() == 0 && !in_valid && expected_hits.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_hits.size() != 0) begin
			$error("hit: %0d results never arrived", expected_hits.size());
			err_cnt++;
		end
		if (err_cnt == 0)
			$display("ray_sphere_hit_test_unit test passed");
		else
			$display("ray_sphere_hit_test_unit test failed");
		$finish;
	end

endmodule
